[sv/dst_pkg.sv]
package dst_pkg;

	// Command codes
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_GET   = 2'd1;
	localparam logic [1:0] CMD_PUT   = 2'd2;
	localparam logic [1:0] CMD_DUP   = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INVAL = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_BADF  = 2'd3;

	localparam logic [15:0] REFS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  slot;
		logic [7:0]  target_slot;
		logic [7:0]  object_id;
		logic [15:0] open_flags;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  result_slot;
		logic [7:0]  entry_object;
		logic [15:0] entry_flags;
		logic [15:0] object_refs;
	} result_t;

	// One slot entry as stored in the slot RAM
	typedef struct packed {
		logic [7:0]  obj;
		logic [15:0] flags;
	} entry_t;

	// Occupancy update: set or clear one slot's open bit
	typedef struct packed {
		logic       set;
		logic       clr;
		logic [7:0] idx;
	} occ_upd_t;

	// Reference count store access request: one read and one write
	typedef struct packed {
		logic        rd_en;
		logic [7:0]  rd_addr;
		logic        wr_en;
		logic [7:0]  wr_addr;
		logic [15:0] wr_data;
	} ref_req_t;

	function automatic logic [15:0] refs_inc(input logic [15:0] cnt);
		refs_inc = (cnt == REFS_MAX) ? cnt : cnt + 16'd1;
	endfunction

	function automatic logic [15:0] refs_dec(input logic [15:0] cnt);
		refs_dec = (cnt == 16'd0) ? cnt : cnt - 16'd1;
	endfunction

endpackage

[sv/dst_ram.sv]
module dst_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/dst_occ.sv]
// Open-slot bitmap and lowest-free-slot encoder.
module dst_occ #(
	parameter int SLOTS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dst_pkg::occ_upd_t    upd,
	output logic [SLOTS-1:0]     occ,
	output logic                 full,
	output logic [7:0]           free_idx
);

	localparam int SW = $clog2(SLOTS);

	logic [SLOTS-1:0] occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (upd.set) begin
			occ_q[upd.idx[SW-1:0]] <= 1'b1;
		end else if (upd.clr) begin
			occ_q[upd.idx[SW-1:0]] <= 1'b0;
		end
	end

	// Scan from the top so the lowest free slot wins
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_idx = 8'(i);
			end
		end
	end

	assign occ  = occ_q;
	assign full = &occ_q;

endmodule

[sv/dst_refs.sv]
// Reference count store: RAM plus per-entry valid bits; an entry never
// written since reset reads as zero.
module dst_refs #(
	parameter int VNODES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dst_pkg::ref_req_t req,
	output logic [15:0]       rdata
);

	localparam int VW = $clog2(VNODES);

	logic [VNODES-1:0] valid_q;
	logic [VW-1:0]     raddr_q;
	logic [15:0]       ram_rdata;

	dst_ram #(
		.WIDTH(16),
		.DEPTH(VNODES)
	) u_ram (
		.clk  (clk),
		.we   (req.wr_en),
		.waddr(req.wr_addr[VW-1:0]),
		.wdata(req.wr_data),
		.re   (req.rd_en),
		.raddr(req.rd_addr[VW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr[VW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			raddr_q <= req.rd_addr[VW-1:0];
		end
	end

	assign rdata = valid_q[raddr_q] ? ram_rdata : 16'd0;

endmodule

[sv/dst_ctrl.sv]
// Command sequencer: walks each command through slot RAM and count store
// read-modify-write steps, one access per store per cycle.
module dst_ctrl #(
	parameter int SLOTS  = 32,
	parameter int VNODES = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  dst_pkg::item_t           item,
	output logic                     busy,
	output logic                     done,
	output dst_pkg::result_t         result,
	output logic                     slot_we,
	output logic [$clog2(SLOTS)-1:0] slot_waddr,
	output dst_pkg::entry_t          slot_wdata,
	output logic                     slot_re,
	output logic [$clog2(SLOTS)-1:0] slot_raddr,
	input  dst_pkg::entry_t          slot_rdata,
	output dst_pkg::occ_upd_t        occ_upd,
	input  logic [SLOTS-1:0]         occ,
	input  logic                     full,
	input  logic [7:0]               free_idx,
	output dst_pkg::ref_req_t        ref_req,
	input  logic [15:0]              ref_rdata
);

	localparam int SW = $clog2(SLOTS);
	localparam logic [8:0] SLOTS_LIM  = 9'(SLOTS);
	localparam logic [8:0] VNODES_LIM = 9'(VNODES);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_TRD  = 4'd2;
	localparam logic [3:0] S_SRD  = 4'd3;
	localparam logic [3:0] S_RDEC = 4'd4;
	localparam logic [3:0] S_SWR  = 4'd5;
	localparam logic [3:0] S_RINC = 4'd6;
	localparam logic [3:0] S_RDN  = 4'd7;
	localparam logic [3:0] S_RGET = 4'd8;

	logic [3:0]       state_q, state_d;
	dst_pkg::item_t   req_q;
	dst_pkg::entry_t  src_q, src_d;
	logic [7:0]       cur_obj_q, cur_obj_d;
	logic [7:0]       rslot_q, rslot_d;
	logic             done_q;
	dst_pkg::result_t result_q, result_d;
	logic             emit;

	logic [SW-1:0] s_idx, t_idx;
	logic          s_ok, t_ok, open_s, obj_ok, same;
	logic [15:0]   cnt_up, cnt_dn;

	assign s_idx  = req_q.slot[SW-1:0];
	assign t_idx  = req_q.target_slot[SW-1:0];
	assign s_ok   = {1'b0, req_q.slot} < SLOTS_LIM;
	assign t_ok   = {1'b0, req_q.target_slot} < SLOTS_LIM;
	assign open_s = s_ok && occ[s_idx];
	assign obj_ok = (req_q.object_id != 8'd0) && ({1'b0, req_q.object_id} < VNODES_LIM);
	assign same   = req_q.slot == req_q.target_slot;
	assign cnt_up = dst_pkg::refs_inc(ref_rdata);
	assign cnt_dn = dst_pkg::refs_dec(ref_rdata);

	always_comb begin
		state_d    = state_q;
		src_d      = src_q;
		cur_obj_d  = cur_obj_q;
		rslot_d    = rslot_q;
		emit       = 1'b0;
		result_d   = '0;
		slot_we    = 1'b0;
		slot_waddr = t_idx;
		slot_wdata = src_q;
		slot_re    = 1'b0;
		slot_raddr = s_idx;
		occ_upd    = '0;
		ref_req    = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				unique case (req_q.cmd)
					dst_pkg::CMD_ALLOC: begin
						if (!obj_ok) begin
							emit            = 1'b1;
							result_d.status = dst_pkg::ST_INVAL;
							state_d         = S_IDLE;
						end else if (full) begin
							emit            = 1'b1;
							result_d.status = dst_pkg::ST_FULL;
							state_d         = S_IDLE;
						end else begin
							slot_we          = 1'b1;
							slot_waddr       = free_idx[SW-1:0];
							slot_wdata.obj   = req_q.object_id;
							slot_wdata.flags = req_q.open_flags;
							occ_upd.set      = 1'b1;
							occ_upd.idx      = free_idx;
							ref_req.rd_en    = 1'b1;
							ref_req.rd_addr  = req_q.object_id;
							cur_obj_d        = req_q.object_id;
							rslot_d          = free_idx;
							state_d          = S_RINC;
						end
					end
					dst_pkg::CMD_GET, dst_pkg::CMD_PUT: begin
						if (!open_s) begin
							emit            = 1'b1;
							result_d.status = dst_pkg::ST_BADF;
							state_d         = S_IDLE;
						end else begin
							slot_re = 1'b1;
							state_d = S_SRD;
						end
					end
					dst_pkg::CMD_DUP: begin
						if (!open_s || !t_ok) begin
							emit            = 1'b1;
							result_d.status = dst_pkg::ST_BADF;
							state_d         = S_IDLE;
						end else if (!same && occ[t_idx]) begin
							// open target: read it first to close it
							slot_re    = 1'b1;
							slot_raddr = t_idx;
							state_d    = S_TRD;
						end else begin
							slot_re = 1'b1;
							state_d = S_SRD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_TRD: begin
				ref_req.rd_en   = 1'b1;
				ref_req.rd_addr = slot_rdata.obj;
				cur_obj_d       = slot_rdata.obj;
				slot_re         = 1'b1;
				state_d         = S_RDEC;
			end
			S_RDEC: begin
				src_d           = slot_rdata;
				ref_req.wr_en   = 1'b1;
				ref_req.wr_addr = cur_obj_q;
				ref_req.wr_data = cnt_dn;
				state_d         = S_SWR;
			end
			S_SRD: begin
				src_d     = slot_rdata;
				cur_obj_d = slot_rdata.obj;
				case (req_q.cmd)
					dst_pkg::CMD_GET: begin
						ref_req.rd_en   = 1'b1;
						ref_req.rd_addr = slot_rdata.obj;
						state_d         = S_RGET;
					end
					dst_pkg::CMD_PUT: begin
						occ_upd.clr     = 1'b1;
						occ_upd.idx     = req_q.slot;
						ref_req.rd_en   = 1'b1;
						ref_req.rd_addr = slot_rdata.obj;
						state_d         = S_RDN;
					end
					default: begin
						if (same) begin
							ref_req.rd_en   = 1'b1;
							ref_req.rd_addr = slot_rdata.obj;
							state_d         = S_RGET;
						end else begin
							state_d = S_SWR;
						end
					end
				endcase
			end
			S_SWR: begin
				slot_we         = 1'b1;
				occ_upd.set     = 1'b1;
				occ_upd.idx     = req_q.target_slot;
				ref_req.rd_en   = 1'b1;
				ref_req.rd_addr = src_q.obj;
				cur_obj_d       = src_q.obj;
				rslot_d         = req_q.target_slot;
				state_d         = S_RINC;
			end
			S_RINC: begin
				ref_req.wr_en        = 1'b1;
				ref_req.wr_addr      = cur_obj_q;
				ref_req.wr_data      = cnt_up;
				emit                 = 1'b1;
				result_d.result_slot = rslot_q;
				result_d.object_refs = cnt_up;
				state_d              = S_IDLE;
			end
			S_RDN: begin
				ref_req.wr_en        = 1'b1;
				ref_req.wr_addr      = cur_obj_q;
				ref_req.wr_data      = cnt_dn;
				emit                 = 1'b1;
				result_d.object_refs = cnt_dn;
				state_d              = S_IDLE;
			end
			S_RGET: begin
				emit                 = 1'b1;
				result_d.object_refs = ref_rdata;
				if (req_q.cmd == dst_pkg::CMD_GET) begin
					result_d.entry_object = src_q.obj;
					result_d.entry_flags  = src_q.flags;
				end else begin
					result_d.result_slot = req_q.target_slot;
				end
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= item;
		end
		src_q     <= src_d;
		cur_obj_q <= cur_obj_d;
		rslot_q   <= rslot_d;
		if (emit) begin
			result_q <= result_d;
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule

[sv/descriptor_slot_table_unit.sv]
// Handle table of SLOTS entries with a per-object reference count store
// of VNODES entries. Raise start with a command on item while busy is low;
// the transaction is taken at that clock edge. Exactly one result comes
// back per command: done is high for one cycle with the result on result,
// and the receiver cannot stall it, so capture it in that cycle. The next
// command may be started in the same cycle that done is high. Busy stays
// high after acceptance while the sequencer steps the command: a rejected
// command is answered at decode, alloc writes the free slot and counts up,
// get, put and dup onto itself read the slot then the count, and dup onto
// a free or open slot also writes the target; done follows in the cycle
// after the last step. Reads of both RAMs are registered; every count
// update is a read followed by a write back, and dup onto an open slot
// closes the target (count down) before opening it again (count up).
// The lowest free slot comes from a priority encoder on a flip-flop
// bitmap of open slots; reset clears that bitmap and the count store's
// valid bits at once, so no clearing pass is needed.
module descriptor_slot_table_unit #(
	parameter int SLOTS  = 32,
	parameter int VNODES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  dst_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output dst_pkg::result_t result
);

	localparam int SW = $clog2(SLOTS);

	logic                slot_we;
	logic [SW-1:0]       slot_waddr;
	dst_pkg::entry_t     slot_wdata;
	logic                slot_re;
	logic [SW-1:0]       slot_raddr;
	dst_pkg::entry_t     slot_rdata;
	dst_pkg::occ_upd_t   occ_upd;
	logic [SLOTS-1:0]    occ;
	logic                full;
	logic [7:0]          free_idx;
	dst_pkg::ref_req_t   ref_req;
	logic [15:0]         ref_rdata;

	// Slot entries: object id and flags; free slots are masked by the bitmap
	dst_ram #(
		.WIDTH($bits(dst_pkg::entry_t)),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.re   (slot_re),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	// Open bitmap and lowest free slot
	dst_occ #(
		.SLOTS(SLOTS)
	) u_occ (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (occ_upd),
		.occ     (occ),
		.full    (full),
		.free_idx(free_idx)
	);

	// Per-object reference counts
	dst_refs #(
		.VNODES(VNODES)
	) u_refs (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ref_req),
		.rdata (ref_rdata)
	);

	// Sequence each transaction through the stores and register its result
	dst_ctrl #(
		.SLOTS (SLOTS),
		.VNODES(VNODES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.slot_we   (slot_we),
		.slot_waddr(slot_waddr),
		.slot_wdata(slot_wdata),
		.slot_re   (slot_re),
		.slot_raddr(slot_raddr),
		.slot_rdata(slot_rdata),
		.occ_upd   (occ_upd),
		.occ       (occ),
		.full      (full),
		.free_idx  (free_idx),
		.ref_req   (ref_req),
		.ref_rdata (ref_rdata)
	);

endmodule

[tb/descriptor_slot_table_checker.sv]
`timescale 1ns / 100ps

module descriptor_slot_table_checker #(
	parameter int SLOTS  = 32,
	parameter int VNODES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  dst_pkg::item_t   item,
	input  logic             done,
	input  dst_pkg::result_t result,
	output int               mismatches,
	output int               outstanding
);

	// Shadow copy of the handle table and the per-object counts
	logic [7:0]  shadow_obj   [SLOTS];
	logic [15:0] shadow_flags [SLOTS];
	logic [15:0] shadow_refs  [VNODES];

	dst_pkg::result_t pending_results [$];
	dst_pkg::result_t oldest_result;
	int               fail_count;

	function automatic logic [15:0] refs_of(input int obj);
		refs_of = (obj < VNODES) ? shadow_refs[obj] : 16'd0;
	endfunction

	function automatic void count_up(input int obj);
		if (obj < VNODES && shadow_refs[obj] != dst_pkg::REFS_MAX)
			shadow_refs[obj] = shadow_refs[obj] + 16'd1;
	endfunction

	function automatic void count_down(input int obj);
		if (obj < VNODES && shadow_refs[obj] != 16'd0)
			shadow_refs[obj] = shadow_refs[obj] - 16'd1;
	endfunction

	function automatic bit slot_is_open(input int s);
		slot_is_open = (s < SLOTS) && (shadow_obj[s] != 8'd0);
	endfunction

	// Apply one command to the shadow table and return the result it gives
	function automatic dst_pkg::result_t apply_command(input dst_pkg::item_t it);
		dst_pkg::result_t r;
		logic [7:0]       o;
		bit               found;
		r = '0;
		found = 1'b0;
		case (it.cmd)
			dst_pkg::CMD_ALLOC: begin
				if (it.object_id == 8'd0 || int'(it.object_id) >= VNODES) begin
					r.status = dst_pkg::ST_INVAL;
				end else begin
					r.status = dst_pkg::ST_FULL;
					// lowest free slot wins
					for (int i = 0; i < SLOTS; i++) begin
						if (!found && shadow_obj[i] == 8'd0) begin
							found = 1'b1;
							shadow_obj[i] = it.object_id;
							shadow_flags[i] = it.open_flags;
							count_up(it.object_id);
							r.status = dst_pkg::ST_OK;
							r.result_slot = i[7:0];
							r.object_refs = refs_of(it.object_id);
						end
					end
				end
			end
			dst_pkg::CMD_GET: begin
				if (!slot_is_open(it.slot)) begin
					r.status = dst_pkg::ST_BADF;
				end else begin
					o = shadow_obj[it.slot];
					r.entry_object = o;
					r.entry_flags = shadow_flags[it.slot];
					r.object_refs = refs_of(o);
				end
			end
			dst_pkg::CMD_PUT: begin
				if (!slot_is_open(it.slot)) begin
					r.status = dst_pkg::ST_BADF;
				end else begin
					o = shadow_obj[it.slot];
					count_down(o);
					shadow_obj[it.slot] = 8'd0;
					shadow_flags[it.slot] = 16'd0;
					r.object_refs = refs_of(o);
				end
			end
			dst_pkg::CMD_DUP: begin
				if (!slot_is_open(it.slot) || int'(it.target_slot) >= SLOTS) begin
					r.status = dst_pkg::ST_BADF;
				end else begin
					o = shadow_obj[it.slot];
					if (it.slot != it.target_slot) begin
						// close the target first, then open it on the source object
						if (shadow_obj[it.target_slot] != 8'd0)
							count_down(shadow_obj[it.target_slot]);
						shadow_obj[it.target_slot] = o;
						shadow_flags[it.target_slot] = shadow_flags[it.slot];
						count_up(o);
					end
					r.result_slot = it.target_slot;
					r.object_refs = refs_of(o);
				end
			end
		endcase
		apply_command = r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				shadow_obj[i] = 8'd0;
				shadow_flags[i] = 16'd0;
			end
			for (int i = 0; i < VNODES; i++)
				shadow_refs[i] = 16'd0;
			pending_results.delete();
			fail_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (done === 1'b1) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with no transaction pending, expected none, actual %h",
						$time, result);
					fail_count++;
				end else begin
					oldest_result = pending_results.pop_front();
					check_field("status", 16'(oldest_result.status), 16'(result.status));
					check_field("result_slot", 16'(oldest_result.result_slot),
						16'(result.result_slot));
					check_field("entry_object", 16'(oldest_result.entry_object),
						16'(result.entry_object));
					check_field("entry_flags", oldest_result.entry_flags, result.entry_flags);
					check_field("object_refs", oldest_result.object_refs, result.object_refs);
				end
			end
			if (start && !busy)
				pending_results.push_back(apply_command(item));
			mismatches <= fail_count;
			outstanding <= pending_results.size();
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

	localparam int SLOTS        = 32;
	localparam int VNODES       = 256;
	localparam int RANDOM_ITEMS = 1550;
	// no transaction and no result for this many cycles means a hang
	localparam int IDLE_LIMIT   = 1000;
	// settle time after the last result: well past the longest command
	localparam int TAIL_CYCLES  = 12;

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             start  = 1'b0;
	dst_pkg::item_t   item   = '0;
	logic             busy;
	logic             done;
	dst_pkg::result_t result;
	int               mismatches;
	int               outstanding;

	int sent_by_cmd [4];
	int directed_sent;
	int random_sent;
	int drain_pauses;
	int idle_cycles;

	// 12 ns clock
	initial begin
		forever #6 clk = ~clk;
	end

	descriptor_slot_table_unit #(
		.SLOTS (SLOTS),
		.VNODES(VNODES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	descriptor_slot_table_checker #(
		.SLOTS (SLOTS),
		.VNODES(VNODES)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	function automatic dst_pkg::item_t make_item(input logic [1:0] cmd,
			input logic [7:0] slot, input logic [7:0] target_slot,
			input logic [7:0] object_id, input logic [15:0] open_flags);
		dst_pkg::item_t it;
		it.cmd = cmd;
		it.slot = slot;
		it.target_slot = target_slot;
		it.object_id = object_id;
		it.open_flags = open_flags;
		make_item = it;
	endfunction

	// Mostly in-range descriptors, some out of range, a few right at the edges
	function automatic logic [7:0] pick_slot();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 85)
			pick_slot = 8'($urandom_range(0, SLOTS - 1));
		else if (roll < 95)
			pick_slot = 8'($urandom_range(SLOTS, 255));
		else
			case ($urandom_range(0, 3))
				0: pick_slot = 8'd0;
				1: pick_slot = 8'(SLOTS - 1);
				2: pick_slot = 8'(SLOTS);
				default: pick_slot = 8'd255;
			endcase
	endfunction

	// Favor a handful of objects so that slots share them and counts climb
	function automatic logic [7:0] pick_object();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			pick_object = 8'($urandom_range(1, 6));
		else if (roll < 95)
			pick_object = 8'($urandom_range(1, 255));
		else
			pick_object = 8'd0;
	endfunction

	// Fully random fields: used for noise on item while start is low
	function automatic dst_pkg::item_t rand_fields();
		rand_fields = make_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			16'($urandom_range(0, 65535)));
	endfunction

	// Command mix per phase: fill the table, empty it, a balanced mix, or dup heavy
	function automatic dst_pkg::item_t random_command(input int mode);
		int         roll;
		logic [1:0] cmd;
		roll = $urandom_range(0, 99);
		case (mode)
			0: cmd = (roll < 80) ? dst_pkg::CMD_ALLOC : (roll < 90) ? dst_pkg::CMD_GET :
				(roll < 95) ? dst_pkg::CMD_PUT : dst_pkg::CMD_DUP;
			1: cmd = (roll < 15) ? dst_pkg::CMD_ALLOC : (roll < 35) ? dst_pkg::CMD_GET :
				(roll < 85) ? dst_pkg::CMD_PUT : dst_pkg::CMD_DUP;
			2: cmd = (roll < 35) ? dst_pkg::CMD_ALLOC : (roll < 60) ? dst_pkg::CMD_GET :
				(roll < 85) ? dst_pkg::CMD_PUT : dst_pkg::CMD_DUP;
			default: cmd = (roll < 20) ? dst_pkg::CMD_ALLOC :
				(roll < 35) ? dst_pkg::CMD_GET :
				(roll < 50) ? dst_pkg::CMD_PUT : dst_pkg::CMD_DUP;
		endcase
		random_command = make_item(cmd, pick_slot(), pick_slot(), pick_object(),
			16'($urandom_range(0, 65535)));
	endfunction

	// Mostly back to back or short gaps, now and then a long one
	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			gap_len = 0;
		else if (roll < 90)
			gap_len = $urandom_range(1, 3);
		else if (roll < 98)
			gap_len = $urandom_range(4, 12);
		else
			gap_len = $urandom_range(20, 40);
	endfunction

	// Present one transaction and hold it until the edge that takes it
	task automatic issue(input dst_pkg::item_t it);
		start <= 1'b1;
		item <= it;
		sent_by_cmd[it.cmd]++;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and drive noise on item for the given gap; zero keeps start high for the next transaction
	task automatic idle(input int n);
		if (n > 0) begin
			start <= 1'b0;
			item <= rand_fields();
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off until every predicted result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic directed(input dst_pkg::item_t it);
		issue(it);
		directed_sent++;
		idle($urandom_range(0, 2));
	endtask

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction or result for %0d cycles", $time, IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int mode;
		int phase_len;
		bit back_to_back;

		idle_cycles = 0;
		directed_sent = 0;
		random_sent = 0;
		drain_pauses = 0;
		for (int i = 0; i < 4; i++)
			sent_by_cmd[i] = 0;

		// Hold reset, then release it on an edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: closed descriptors on an empty table first
		directed(make_item(dst_pkg::CMD_GET, 8'd0, 8'd0, 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_PUT, 8'(SLOTS - 1), 8'd0, 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_DUP, 8'd0, 8'd1, 8'd0, 16'h0000));
		// alloc with no object
		directed(make_item(dst_pkg::CMD_ALLOC, 8'd0, 8'd0, 8'd0, 16'hFFFF));
		// allocs with extreme objects and flags: slots 0, 1, 2
		directed(make_item(dst_pkg::CMD_ALLOC, 8'hFF, 8'hFF, 8'd255, 16'hFFFF));
		directed(make_item(dst_pkg::CMD_ALLOC, 8'd0, 8'd0, 8'd1, 16'h0000));
		directed(make_item(dst_pkg::CMD_ALLOC, 8'd0, 8'd0, 8'd255, 16'hA5A5));
		directed(make_item(dst_pkg::CMD_GET, 8'd0, 8'd0, 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_GET, 8'd2, 8'hFF, 8'hFF, 16'hFFFF));
		// descriptors just past the table and at the top of the field
		directed(make_item(dst_pkg::CMD_GET, 8'(SLOTS), 8'd0, 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_GET, 8'd255, 8'd0, 8'd0, 16'h0000));
		// dup onto itself, onto a free slot, onto an open slot
		directed(make_item(dst_pkg::CMD_DUP, 8'd0, 8'd0, 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_DUP, 8'd0, 8'd5, 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_DUP, 8'd1, 8'd5, 8'd0, 16'h0000));
		// bad dup targets and sources
		directed(make_item(dst_pkg::CMD_DUP, 8'd0, 8'(SLOTS), 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_DUP, 8'd0, 8'd255, 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_DUP, 8'd255, 8'd3, 8'd0, 16'h0000));
		// close, close again, close out of range, read a closed slot
		directed(make_item(dst_pkg::CMD_PUT, 8'd5, 8'd0, 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_PUT, 8'd5, 8'd0, 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_PUT, 8'd255, 8'd0, 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_GET, 8'd5, 8'd0, 8'd0, 16'h0000));
		// lowest free slot after a hole, then the top slot
		directed(make_item(dst_pkg::CMD_ALLOC, 8'd0, 8'd0, 8'd128, 16'h8000));
		directed(make_item(dst_pkg::CMD_DUP, 8'd2, 8'(SLOTS - 1), 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_GET, 8'(SLOTS - 1), 8'd0, 8'd0, 16'h0000));
		directed(make_item(dst_pkg::CMD_PUT, 8'd0, 8'd0, 8'd0, 16'h0000));

		// Let everything settle before the random phases
		drain();
		drain_pauses++;

		// Random part: phases of a given mix, some back to back, some with pauses
		while (random_sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 3);
			back_to_back = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(30, 120);
			for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
				issue(random_command(mode));
				random_sent++;
				idle(back_to_back ? 0 : gap_len());
			end
			if ($urandom_range(0, 2) == 0) begin
				drain();
				drain_pauses++;
			end
		end

		// Wait for the last results, then give the block time to misbehave
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d directed and %0d random commands: alloc %0d, get %0d, put %0d, dup %0d",
			directed_sent, random_sent, sent_by_cmd[dst_pkg::CMD_ALLOC],
			sent_by_cmd[dst_pkg::CMD_GET], sent_by_cmd[dst_pkg::CMD_PUT],
			sent_by_cmd[dst_pkg::CMD_DUP]);
		$display("Mixed fill, empty and dup phases with random gaps and %0d full drains",
			drain_pauses);
		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
